// ----- hdl/texswz_pkg.sv -----
// package for the morton texture swizzle address generator
// holds sizes, config register indexes, the bit spreading function and the log2 clamp
// no dependencies
package texswz_pkg;

  // largest surface side as log2, also the counter width
  localparam int unsigned MaxDimLog2 = 11;
  localparam int unsigned CntW       = MaxDimLog2;
  localparam int unsigned Log2W      = 4;
  localparam int unsigned BppW       = 3;
  localparam int unsigned AddrW      = 24;
  localparam int unsigned PixW       = 32;
  localparam int unsigned SpreadW    = 2 * CntW;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 4;

  // reset values of the config registers
  localparam logic [Log2W-1:0] WidthLog2Rst  = Log2W'(8);
  localparam logic [Log2W-1:0] HeightLog2Rst = Log2W'(8);
  localparam logic [BppW-1:0]  BppRst        = BppW'(4);

  // config register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH_LOG2  = 2'd0,
    CFG_HEIGHT_LOG2 = 2'd1,
    CFG_BPP         = 2'd2
  } cfg_idx_e;

  // bit i of the operand goes to bit 2i
  function automatic logic [SpreadW-1:0] spread_bits(input logic [CntW-1:0] v);
    logic [SpreadW-1:0] r;
    r = '0;
    for (int unsigned b = 0; b < CntW; b++) begin
      r[2*b] = v[b];
    end
    return r;
  endfunction

  // log2 above the supported limit is taken as the limit
  function automatic logic [Log2W-1:0] clamp_log2(input logic [Log2W-1:0] v);
    return (v > Log2W'(MaxDimLog2)) ? Log2W'(MaxDimLog2) : v;
  endfunction

endpackage

// ----- hdl/texswz_in_if.sv -----
// item channel carrying source pixels into the swizzle block
// depends on texswz_pkg
interface texswz_in_if
  import texswz_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ----- hdl/texswz_out_if.sv -----
// item channel carrying swizzled addresses and pixels out of the block
// depends on texswz_pkg
interface texswz_out_if
  import texswz_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] byte_address;
  logic [PixW-1:0]  pixel_out;
  logic             image_end;

  modport source (output valid, output byte_address, output pixel_out, output image_end,
                  input ready);
  modport sink   (input valid, input byte_address, input pixel_out, input image_end,
                  output ready);
endinterface

// ----- hdl/texture_swizzle_address.sv -----
// top level of the morton texture swizzle address generator
// an accepted item passes the input register, then the result register
// throughput: one item per cycle unless the result side holds ready low,
// two register stages (input and result)
// reset: counters clear to zero, registers go to width 256, height 256, 4 bytes
// depends on texswz_pkg, texswz_in_if, texswz_out_if, texswz_addr_calc
module texture_swizzle_address
  import texswz_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  texswz_in_if.sink           pix_i,
  texswz_out_if.source        res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // config registers
  logic [Log2W-1:0] width_log2_q;
  logic [Log2W-1:0] height_log2_q;
  logic [BppW-1:0]  bpp_q;

  // position counters
  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;

  // input stage
  logic            s1_valid_q;
  logic [PixW-1:0] s1_pixel_q;
  logic [CntW-1:0] s1_col_q;
  logic [CntW-1:0] s1_row_q;
  logic            s1_end_q;

  // result stage
  logic             s2_valid_q;
  logic [AddrW-1:0] s2_addr_q;
  logic [PixW-1:0]  s2_pixel_q;
  logic             s2_end_q;

  logic             s2_adv;
  logic             s1_adv;
  logic             in_acc;
  logic [Log2W-1:0] wl;
  logic [Log2W-1:0] hl;
  logic [CntW-1:0]  col_lim;
  logic [CntW-1:0]  row_lim;
  logic             col_last;
  logic             row_last;
  logic [AddrW-1:0] addr;

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= WidthLog2Rst;
      height_log2_q <= HeightLog2Rst;
      bpp_q         <= BppRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH_LOG2:  width_log2_q  <= cfg_data_i[Log2W-1:0];
        CFG_HEIGHT_LOG2: height_log2_q <= cfg_data_i[Log2W-1:0];
        CFG_BPP:         bpp_q         <= cfg_data_i[BppW-1:0];
        default: ;
      endcase
    end
  end

  assign wl = clamp_log2(width_log2_q);
  assign hl = clamp_log2(height_log2_q);

  // pipeline flow control
  assign s2_adv    = !s2_valid_q || res_o.ready;
  assign s1_adv    = !s1_valid_q || s2_adv;
  assign pix_i.ready = s1_adv;
  assign in_acc    = pix_i.valid && s1_adv;

  // end of row and end of image checks
  assign col_lim  = CntW'((32'd1 << wl) - 32'd1);
  assign row_lim  = CntW'((32'd1 << hl) - 32'd1);
  assign col_last = col_q >= col_lim;
  assign row_last = row_q >= row_lim;

  // counter next state
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pixel_q <= pix_i.pixel_value;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_end_q   <= col_last && row_last;
    end
  end

  texswz_addr_calc u_addr_calc (
    .col_i  (s1_col_q),
    .row_i  (s1_row_q),
    .wl_i   (wl),
    .hl_i   (hl),
    .bpp_i  (bpp_q),
    .addr_o (addr)
  );

  // result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      s2_addr_q  <= addr;
      s2_pixel_q <= s1_pixel_q;
      s2_end_q   <= s1_end_q;
    end
  end

  assign res_o.valid        = s2_valid_q;
  assign res_o.byte_address = s2_addr_q;
  assign res_o.pixel_out    = s2_pixel_q;
  assign res_o.image_end    = s2_end_q;

  // last pixel of the image returns both counters to zero
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && col_last && row_last |=> col_q == '0 && row_q == '0)
    else $error("counters not cleared after last pixel");

  // a pixel inside a row steps the column only
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !col_last |=> col_q == $past(col_q) + CntW'(1) && row_q == $past(row_q))
    else $error("column counter did not step");

  // a result appears only from an item held in the input stage
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_valid_q))
    else $error("result without a pending item");

  // an empty result stage never blocks the input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_valid_q |-> pix_i.ready)
    else $error("input stalled with empty result stage");

endmodule

// ----- hdl/texswz_addr_calc.sv -----
// morton swizzled byte address of one pixel from its column and row
// depends on texswz_pkg
module texswz_addr_calc
  import texswz_pkg::*;
(
  input  logic [CntW-1:0]  col_i,
  input  logic [CntW-1:0]  row_i,
  input  logic [Log2W-1:0] wl_i,
  input  logic [Log2W-1:0] hl_i,
  input  logic [BppW-1:0]  bpp_i,
  output logic [AddrW-1:0] addr_o
);

  localparam logic [CntW-1:0] AllOnes = '1;

  logic [Log2W:0]   wl_x2;
  logic [Log2W-1:0] hl_p1;
  logic [Log2W:0]   hl_x2p1;
  logic [CntW-1:0]  row_lo;
  logic [CntW-1:0]  col_lo;
  logic [AddrW-1:0] row_wide;
  logic [AddrW-1:0] col_wide;
  logic [AddrW-1:0] sy;
  logic [AddrW-1:0] sx;
  logic [AddrW-1:0] idx;

  // shift amounts
  assign wl_x2   = {wl_i, 1'b0};
  assign hl_p1   = hl_i + Log2W'(1);
  assign hl_x2p1 = {hl_i, 1'b1};

  // low part of row wraps by width, low part of column by twice the height
  assign row_lo = row_i & ~(AllOnes << wl_i);
  assign col_lo = col_i & ~(AllOnes << hl_p1);

  assign row_wide = AddrW'(row_i);
  assign col_wide = AddrW'(col_i);

  // interleaved part plus tile offset
  assign sy = (AddrW'(spread_bits(row_lo)) << 1) + ((row_wide >> wl_i) << wl_x2);
  assign sx = AddrW'(spread_bits(col_lo)) + ((col_wide >> hl_p1) << hl_x2p1);

  // scale the element index to bytes, kept to the address width
  assign idx    = sx + sy;
  assign addr_o = AddrW'(idx * bpp_i);

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the morton texture swizzle address generator
// drives a directed table and random pixel phases, predicts addresses in place
// depends on texswz_pkg, texswz_in_if, texswz_out_if and texture_swizzle_address
module testbench
  import texswz_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // interleave span of the address spreading
  localparam int unsigned SpreadBits   = 16;
  // register index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned RandomItems  = 330;
  localparam int unsigned ClimbItems   = 160;
  localparam int unsigned FinalItems   = 100;
  localparam int unsigned ScriptLen    = 35;

  typedef struct packed {
    logic [AddrW-1:0] byte_address;
    logic [PixW-1:0]  pixel_out;
    logic             image_end;
  } swizzled_pixel_t;

  typedef enum logic {
    STEP_PIXEL,
    STEP_WRITE
  } step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [PixW-1:0]     pixel;
    logic                typed;
    logic [AddrW-1:0]    addr;
    logic                last;
  } script_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  texswz_in_if  pix_if ();
  texswz_out_if res_if ();

  texture_swizzle_address i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if.sink),
    .res_o      (res_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // surface settings and pixel position as the block should hold them
  logic [Log2W-1:0] width_log2_q  = WidthLog2Rst;
  logic [Log2W-1:0] height_log2_q = HeightLog2Rst;
  logic [BppW-1:0]  bytes_pp_q    = BppRst;
  logic [CntW-1:0]  column_q      = '0;
  logic [CntW-1:0]  row_q         = '0;

  swizzled_pixel_t swizzled_pixels_q [$];
  int unsigned     fail_count = 0;
  bit              tx_gaps    = 1'b0;
  bit              rx_stalls  = 1'b0;

  // directed items: reset values, clamps, masks, mid-image changes
  script_row_t script [ScriptLen] = '{
    '{STEP_PIXEL, '0, 4'h0, 32'h0000_0000, 1'b1, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'hFFFF_FFFF, 1'b1, 24'd4,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'hA5A5_5A5A, 1'b1, 24'd16, 1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h8000_0000, 1'b0, 24'd0,  1'b0},
    '{STEP_WRITE, CFG_WIDTH_LOG2,  4'h0, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_WRITE, CFG_HEIGHT_LOG2, 4'h0, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h0000_0001, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h1234_5678, 1'b1, 24'd0,  1'b1},
    '{STEP_WRITE, CFG_BPP,         4'h0, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'hFFFF_FFFF, 1'b1, 24'd0,  1'b1},
    '{STEP_WRITE, CfgIdxUnused,    4'hF, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'hDEAD_BEEF, 1'b1, 24'd0,  1'b1},
    '{STEP_WRITE, CFG_WIDTH_LOG2,  4'hF, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_WRITE, CFG_HEIGHT_LOG2, 4'hF, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_WRITE, CFG_BPP,         4'hF, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h0F0F_F0F0, 1'b1, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'hF0F0_0F0F, 1'b1, 24'd7,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h7FFF_FFFF, 1'b0, 24'd0,  1'b0},
    '{STEP_WRITE, CFG_WIDTH_LOG2,  4'h1, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_WRITE, CFG_HEIGHT_LOG2, 4'h1, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_WRITE, CFG_BPP,         4'h9, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h5555_AAAA, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'hAAAA_5555, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h0000_FFFF, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'hFFFF_0000, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h0000_0000, 1'b0, 24'd0,  1'b0},
    '{STEP_WRITE, CFG_BPP,         4'h3, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_WRITE, CFG_WIDTH_LOG2,  4'h2, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_WRITE, CFG_HEIGHT_LOG2, 4'h0, 32'h0, 1'b0, 24'd0, 1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h1111_1111, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h2222_2222, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h4444_4444, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h8888_8888, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'h0000_0000, 1'b0, 24'd0,  1'b0},
    '{STEP_PIXEL, '0, 4'h0, 32'hFFFF_FFFF, 1'b0, 24'd0,  1'b0}
  };

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // bit i moves to bit 2i
  function automatic logic [63:0] dilate_bits(input logic [63:0] v);
    logic [63:0] r;
    r = '0;
    for (int unsigned b = 0; b < SpreadBits; b++) begin
      r[2*b] = v[b];
    end
    return r;
  endfunction

  // address of the current pixel, then step the column and row
  function automatic swizzled_pixel_t swizzle_next_pixel(input logic [PixW-1:0] pixel);
    int unsigned     wl;
    int unsigned     hl;
    logic [63:0]     w;
    logic [63:0]     h;
    logic [63:0]     x;
    logic [63:0]     y;
    logic [63:0]     sx;
    logic [63:0]     sy;
    logic [63:0]     addr;
    logic            col_last;
    logic            row_last;
    swizzled_pixel_t res;
    wl = width_log2_q;
    hl = height_log2_q;
    if (wl > MaxDimLog2) wl = MaxDimLog2;
    if (hl > MaxDimLog2) hl = MaxDimLog2;
    w = 64'd1 << wl;
    h = 64'd1 << hl;
    x = 64'(column_q);
    y = 64'(row_q);
    // row takes the odd bits, rows past the width start a new tile
    sy = (dilate_bits(y & (w - 1)) << 1) + ((y >> wl) << (2 * wl));
    // columns past twice the height start a new tile
    sx = dilate_bits(x & (2 * h - 1)) + ((x >> (hl + 1)) << (2 * hl + 1));
    addr = (sx + sy) * 64'(bytes_pp_q);
    col_last = (x >= w - 1);
    row_last = (y >= h - 1);
    res.byte_address = addr[AddrW-1:0];
    res.pixel_out    = pixel;
    res.image_end    = col_last && row_last;
    if (col_last) begin
      column_q = '0;
      row_q    = row_last ? '0 : row_q + 1'b1;
    end else begin
      column_q = column_q + 1'b1;
    end
    return res;
  endfunction

  function automatic logic [PixW-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly tiny surfaces so images end often
  function automatic logic [CfgDataW-1:0] random_log2();
    if ($urandom_range(0, 7) == 0) return CfgDataW'($urandom_range(0, 15));
    return CfgDataW'($urandom_range(0, 3));
  endfunction

  // register write, the enable stays up until the next pixel
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH_LOG2:  width_log2_q  = data;
      CFG_HEIGHT_LOG2: height_log2_q = data;
      CFG_BPP:         bytes_pp_q    = data[BppW-1:0];
      default: ;
    endcase
  endtask

  // offer one pixel item and record its expected result once taken
  task automatic send_pixel(input logic [PixW-1:0] pixel, input logic typed = 1'b0,
                            input logic [AddrW-1:0] typed_addr = '0,
                            input logic typed_end = 1'b0);
    swizzled_pixel_t want;
    cfg_we_i <= 1'b0;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= pixel;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    want = swizzle_next_pixel(pixel);
    if (typed) begin
      want.byte_address = typed_addr;
      want.image_end    = typed_end;
    end
    swizzled_pixels_q.push_back(want);
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (swizzled_pixels_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // result side back pressure
  initial begin : result_sink
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (rx_stalls && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin : check_results
    swizzled_pixel_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (swizzled_pixels_q.size() == 0) begin
        $error("result item with none expected: byte_address %0h pixel_out %0h",
               res_if.byte_address, res_if.pixel_out);
        fail_count++;
      end else begin
        want = swizzled_pixels_q.pop_front();
        if (res_if.byte_address !== want.byte_address) begin
          $error("byte_address: expected %0h, got %0h", want.byte_address,
                 res_if.byte_address);
          fail_count++;
        end
        if (res_if.pixel_out !== want.pixel_out) begin
          $error("pixel_out: expected %0h, got %0h", want.pixel_out, res_if.pixel_out);
          fail_count++;
        end
        if (res_if.image_end !== want.image_end) begin
          $error("image_end: expected %0b, got %0b", want.image_end, res_if.image_end);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    bit          streaming;
    bit          climbed;
    int unsigned random_count;
    int unsigned n;
    int unsigned mode;
    rst_ni             <= 1'b0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_value <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= '0;
    cfg_data_i         <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    streaming = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE) begin
        if (streaming) settle();
        streaming = 1'b0;
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_pixel(script[i].pixel, script[i].typed, script[i].addr, script[i].last);
        streaming = 1'b1;
      end
    end

    // random phases, each with its own surface and idling mix
    random_count = 0;
    climbed      = 1'b0;
    while (random_count < RandomItems) begin
      settle();
      mode      = $urandom_range(0, 3);
      tx_gaps   = mode[0];
      rx_stalls = mode[1];
      if (!climbed && random_count >= RandomItems / 2) begin
        // one column image pushes the row counter up, then a wide surface
        // gives large tiled addresses
        write_reg(CFG_WIDTH_LOG2, 4'd0);
        write_reg(CFG_HEIGHT_LOG2, 4'd0);
        send_pixel(random_pixel());
        settle();
        write_reg(CFG_HEIGHT_LOG2, CfgDataW'(MaxDimLog2));
        write_reg(CFG_BPP, 4'd7);
        repeat (ClimbItems) send_pixel(random_pixel());
        settle();
        write_reg(CFG_WIDTH_LOG2, CfgDataW'(MaxDimLog2));
        repeat (40) send_pixel(random_pixel());
        climbed = 1'b1;
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(CFG_WIDTH_LOG2, random_log2());
        if ($urandom_range(0, 3) != 0) write_reg(CFG_HEIGHT_LOG2, random_log2());
        if ($urandom_range(0, 2) != 0) write_reg(CFG_BPP, CfgDataW'($urandom_range(0, 15)));
        if ($urandom_range(0, 15) == 0) write_reg(CfgIdxUnused, CfgDataW'($urandom));
        n = $urandom_range(4, 48);
        repeat (n) send_pixel(random_pixel());
        random_count += n;
      end
    end

    // closing stretch at full rate
    settle();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_reg(CFG_WIDTH_LOG2, CfgDataW'($urandom_range(0, 3)));
    write_reg(CFG_HEIGHT_LOG2, CfgDataW'($urandom_range(0, 3)));
    write_reg(CFG_BPP, CfgDataW'($urandom_range(1, 4)));
    repeat (FinalItems) send_pixel(random_pixel());

    settle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #3_000_000;
    $error("run did not finish in time, %0d results outstanding", swizzled_pixels_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/texswz_pkg.sv
hdl/texswz_in_if.sv
hdl/texswz_out_if.sv
hdl/texswz_addr_calc.sv
hdl/texture_swizzle_address.sv
verif/testbench.sv
